// ===== rtl/calu_pkg.sv =====
`timescale 1ns / 1ps
package calu_pkg;

  typedef enum logic [4:0] {
    K_INC8 = 5'd0, K_INCX8 = 5'd1, K_DEC8 = 5'd2, K_DECX8 = 5'd3,
    K_INC16 = 5'd4, K_DEC16 = 5'd5,
    K_ADDA = 5'd6, K_ADCA = 5'd7, K_SUBA = 5'd8, K_SBCA = 5'd9,
    K_ANDA = 5'd10, K_XORA = 5'd11, K_ORA = 5'd12, K_CPA = 5'd13,
    K_ADDHL = 5'd14, K_ADCHL = 5'd15, K_SUBHL = 5'd16, K_SBCHL = 5'd17,
    K_ANDHL = 5'd18, K_XORHL = 5'd19, K_ORHL = 5'd20,
    K_LDA = 5'd21, K_LDHL = 5'd22, K_LDF = 5'd23
  } kind_t;

  localparam int FB_S = 7;
  localparam int FB_Z = 6;
  localparam int FB_H = 4;
  localparam int FB_X = 3;
  localparam int FB_V = 2;
  localparam int FB_N = 1;
  localparam int FB_C = 0;

  // decoded request between front and back
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] operand;
  } req_t;

endpackage

// ===== rtl/calu_front.sv =====
`timescale 1ns / 1ps
module calu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [4:0]           in_kind,
  input  logic [15:0]          in_operand,
  output logic                 q_valid,
  input  logic                 q_ready,
  output calu_pkg::req_t       q_req
);
  import calu_pkg::*;

  // two-entry queue toward the execute side
  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{kind: in_kind, operand: in_operand};
  end
endmodule

// ===== rtl/calu_back.sv =====
`timescale 1ns / 1ps
module calu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  calu_pkg::req_t q_req,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    out_value,
  output logic [7:0]     out_flags_out,
  output logic           out_write_back
);
  import calu_pkg::*;

  logic [7:0]  acc_r, acc_nxt;
  logic [15:0] hl_r, hl_nxt;
  logic [7:0]  f_r, f_nxt;
  logic [15:0] v;
  logic        wb;
  logic        fire;
  logic [7:0]  b, r8;
  logic [15:0] w, r16;
  logic        c, cin;
  logic [8:0]  s9;
  logic [16:0] s17;
  logic [4:0]  h5;
  logic [12:0] h13;

  assign q_ready = !out_valid || out_ready;
  assign fire    = q_valid && q_ready;
  assign b = q_req.operand[7:0];
  assign w = q_req.operand;
  assign c = f_r[FB_C];

  // execute one request against the register state
  always_comb begin
    acc_nxt = acc_r; hl_nxt = hl_r; f_nxt = f_r;
    v = '0; wb = 1'b1;
    cin = 1'b0; s9 = '0; s17 = '0; h5 = '0; h13 = '0; r8 = '0; r16 = '0;
    case (q_req.kind)
      K_INC8, K_INCX8, K_DEC8, K_DECX8: begin
        if ((q_req.kind == K_INCX8 || q_req.kind == K_DECX8) && !f_r[FB_X]) begin
          v = {8'd0, b}; wb = 1'b0;
        end else if (q_req.kind == K_INC8 || q_req.kind == K_INCX8) begin
          r8 = b + 8'd1;
          f_nxt[FB_S] = r8[7]; f_nxt[FB_Z] = (r8 == 8'd0);
          f_nxt[FB_X] = (b == 8'hff); f_nxt[FB_V] = (b == 8'h7f);
          f_nxt[FB_H] = (r8[3:0] == 4'd0);
          v = {8'd0, r8};
        end else begin
          r8 = b - 8'd1;
          f_nxt[FB_S] = r8[7]; f_nxt[FB_Z] = (r8 == 8'd0);
          f_nxt[FB_X] = (b == 8'h00); f_nxt[FB_V] = (b == 8'h80);
          f_nxt[FB_H] = (b[3:0] == 4'd0); f_nxt[FB_N] = 1'b1;
          v = {8'd0, r8};
        end
      end
      K_INC16, K_DEC16: begin
        r16 = (q_req.kind == K_INC16) ? w + 16'd1 : w - 16'd1;
        f_nxt[FB_S] = r16[15]; f_nxt[FB_Z] = (r16 == 16'd0); f_nxt[FB_N] = 1'b0;
        f_nxt[FB_X] = (q_req.kind == K_INC16) ? (r16 == 16'd0) : (w == 16'd0);
        f_nxt[FB_V] = f_nxt[FB_X];
        v = r16;
      end
      K_ADDA, K_ADCA: begin
        cin = (q_req.kind == K_ADCA) & c;
        s9 = {1'b0, acc_r} + {1'b0, b} + {8'd0, cin};
        h5 = {1'b0, acc_r[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
        r8 = s9[7:0];
        f_nxt[FB_S] = r8[7]; f_nxt[FB_Z] = (r8 == 8'd0); f_nxt[FB_H] = h5[4];
        f_nxt[FB_X] = s9[8]; f_nxt[FB_C] = s9[8]; f_nxt[FB_N] = 1'b0;
        f_nxt[FB_V] = ~(acc_r[7] ^ b[7]) & (acc_r[7] ^ r8[7]);
        acc_nxt = r8; v = {8'd0, r8};
      end
      K_SUBA, K_SBCA, K_CPA: begin
        cin = (q_req.kind == K_SBCA) & c;
        s9 = {1'b0, acc_r} - {1'b0, b} - {8'd0, cin};
        h5 = {1'b0, acc_r[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
        r8 = s9[7:0];
        f_nxt[FB_S] = r8[7]; f_nxt[FB_Z] = (r8 == 8'd0); f_nxt[FB_H] = h5[4];
        f_nxt[FB_X] = s9[8]; f_nxt[FB_C] = s9[8]; f_nxt[FB_N] = 1'b1;
        f_nxt[FB_V] = (acc_r[7] ^ b[7]) & (acc_r[7] ^ r8[7]);
        v = {8'd0, r8};
        if (q_req.kind == K_CPA) wb = 1'b0;
        else acc_nxt = r8;
      end
      K_ANDA, K_XORA, K_ORA: begin
        r8 = (q_req.kind == K_ANDA) ? (acc_r & b) :
             (q_req.kind == K_XORA) ? (acc_r ^ b) : (acc_r | b);
        f_nxt[FB_S] = r8[7]; f_nxt[FB_Z] = (r8 == 8'd0);
        f_nxt[FB_H] = (q_req.kind == K_ANDA); f_nxt[FB_X] = 1'b0;
        f_nxt[FB_V] = ~^r8; f_nxt[FB_N] = 1'b0; f_nxt[FB_C] = 1'b0;
        acc_nxt = r8; v = {8'd0, r8};
      end
      K_ADDHL, K_ADCHL: begin
        cin = (q_req.kind == K_ADCHL) & c;
        s17 = {1'b0, hl_r} + {1'b0, w} + {16'd0, cin};
        r16 = s17[15:0];
        f_nxt[FB_S] = r16[15]; f_nxt[FB_Z] = (r16 == 16'd0);
        f_nxt[FB_X] = s17[16]; f_nxt[FB_C] = s17[16]; f_nxt[FB_N] = 1'b0;
        f_nxt[FB_V] = ~(hl_r[15] ^ w[15]) & (hl_r[15] ^ r16[15]);
        hl_nxt = r16; v = r16;
      end
      K_SUBHL, K_SBCHL: begin
        cin = (q_req.kind == K_SBCHL) & c;
        s17 = {1'b0, hl_r} - {1'b0, w} - {16'd0, cin};
        h13 = {1'b0, hl_r[11:0]} - {1'b0, w[11:0]} - {12'd0, cin};
        r16 = s17[15:0];
        f_nxt[FB_S] = r16[15]; f_nxt[FB_Z] = (r16 == 16'd0);
        f_nxt[FB_X] = s17[16]; f_nxt[FB_C] = s17[16]; f_nxt[FB_N] = 1'b1;
        f_nxt[FB_V] = (hl_r[15] ^ w[15]) & (hl_r[15] ^ r16[15]);
        if (q_req.kind == K_SBCHL) f_nxt[FB_H] = h13[12];
        hl_nxt = r16; v = r16;
      end
      K_ANDHL, K_XORHL, K_ORHL: begin
        r16 = (q_req.kind == K_ANDHL) ? (hl_r & w) :
              (q_req.kind == K_XORHL) ? (hl_r ^ w) : (hl_r | w);
        f_nxt[FB_S] = r16[15]; f_nxt[FB_Z] = (r16 == 16'd0);
        f_nxt[FB_H] = (q_req.kind == K_ANDHL); f_nxt[FB_X] = 1'b0;
        f_nxt[FB_N] = 1'b0; f_nxt[FB_C] = 1'b0;
        hl_nxt = r16; v = r16;
      end
      K_LDA:  begin acc_nxt = b; v = {8'd0, b}; end
      K_LDHL: begin hl_nxt = w; v = w; end
      K_LDF:  begin f_nxt = b; v = {8'd0, b}; end
      default: begin v = '0; wb = 1'b0; end
    endcase
  end

  // architectural state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0; hl_r <= '0; f_r <= '0; out_valid <= 1'b0;
    end else begin
      if (fire) begin
        acc_r <= acc_nxt; hl_r <= hl_nxt; f_r <= f_nxt;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_value <= v; out_flags_out <= f_nxt; out_write_back <= wb;
    end
  end
endmodule

// ===== rtl/cpu_alu_8_16_with_flags.sv =====
`timescale 1ns / 1ps
// a request is written into the queue register, then its result into the execute register
// throughput: one request per cycle while the receiver takes each result;
// the flag and register loop closes in the execute stage
// a two-entry queue separates intake from execution so either side may stall
// reset: synchronous active-low; clears A, HL, flags, queue and result valid
module cpu_alu_8_16_with_flags (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_kind,
  input  logic [15:0] in_operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_value,
  output logic [7:0]  out_flags_out,
  output logic        out_write_back
);
  import calu_pkg::*;

  logic q_valid, q_ready;
  req_t q_req;

  // intake queue
  calu_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_operand,
    .q_valid, .q_ready, .q_req
  );

  // execute stage
  calu_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_req,
    .out_valid, .out_ready, .out_value, .out_flags_out, .out_write_back
  );

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_flags_out))
    else $error("result changed while stalled");

  // compare and unused kinds never write back
  a_wb: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready && (q_req.kind == K_CPA || q_req.kind > K_LDF)
    |=> !out_write_back)
    else $error("write back on non-storing kind");

  // queue only drains into the execute stage when it can take it
  a_q: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !q_ready)
    else $error("execute took request while result stalled");
endmodule

// ===== sim/tb_cpu_alu_8_16_with_flags.sv =====
`timescale 1ns / 1ps
module tb_cpu_alu_8_16_with_flags;
  import calu_pkg::*;

  localparam logic [7:0] FM_S = 8'h80;
  localparam logic [7:0] FM_Z = 8'h40;
  localparam logic [7:0] FM_H = 8'h10;
  localparam logic [7:0] FM_X = 8'h08;
  localparam logic [7:0] FM_V = 8'h04;
  localparam logic [7:0] FM_N = 8'h02;
  localparam logic [7:0] FM_C = 8'h01;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  flags;
    logic        wb;
  } alu_result_t;

  // golden alu state plus queue of pending results
  class alu_scoreboard;
    logic [7:0]  acc;
    logic [15:0] hl;
    logic [7:0]  fl;
    alu_result_t pending[$];
    int errors;
    int checked;

    function void clear();
      acc = '0; hl = '0; fl = '0;
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function logic [7:0] sz8(logic [7:0] r);
      sz8 = (r[7] ? FM_S : 8'h00) | (r == 8'h00 ? FM_Z : 8'h00);
    endfunction

    function logic [7:0] sz16(logic [15:0] r);
      sz16 = (r[15] ? FM_S : 8'h00) | (r == 16'h0000 ? FM_Z : 8'h00);
    endfunction

    function logic [7:0] add8(logic [7:0] a, logic [7:0] b, logic c);
      logic [8:0] r;
      logic [7:0] f;
      r = {1'b0, a} + {1'b0, b} + 9'(c);
      f = fl & FM_I_ONLY();
      f |= sz8(r[7:0]);
      if ({1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(c) > 5'h0f) f |= FM_H;
      if (r[8]) f |= FM_X | FM_C;
      if (~(a[7] ^ b[7]) & (a[7] ^ r[7])) f |= FM_V;
      fl = f;
      add8 = r[7:0];
    endfunction

    function logic [7:0] FM_I_ONLY();
      FM_I_ONLY = 8'h20;
    endfunction

    function logic [7:0] sub8(logic [7:0] a, logic [7:0] b, logic c);
      logic [7:0] r;
      logic [7:0] f;
      r = a - b - 8'(c);
      f = (fl & ~(FM_S | FM_Z | FM_H | FM_X | FM_V | FM_C)) | FM_N | sz8(r);
      if ({1'b0, a[3:0]} < {1'b0, b[3:0]} + 5'(c)) f |= FM_H;
      if ({1'b0, a} < {1'b0, b} + 9'(c)) f |= FM_C | FM_X;
      if ((a[7] ^ b[7]) & (a[7] ^ r[7])) f |= FM_V;
      fl = f;
      sub8 = r;
    endfunction

    function logic [7:0] logic8(logic [7:0] r, logic is_and);
      fl = (fl & FM_I_ONLY()) | sz8(r) | (^r ? 8'h00 : FM_V) | (is_and ? FM_H : 8'h00);
      logic8 = r;
    endfunction

    function logic [15:0] add16(logic [15:0] a, logic [15:0] b, logic c);
      logic [16:0] r;
      logic [7:0] f;
      r = {1'b0, a} + {1'b0, b} + 17'(c);
      f = (fl & ~(FM_S | FM_Z | FM_X | FM_V | FM_N | FM_C)) | sz16(r[15:0]);
      if (r[16]) f |= FM_X | FM_C;
      if (~(a[15] ^ b[15]) & (a[15] ^ r[15])) f |= FM_V;
      fl = f;
      add16 = r[15:0];
    endfunction

    function logic [15:0] sub16(logic [15:0] a, logic [15:0] b, logic c, logic half);
      logic [15:0] r;
      logic [7:0] f;
      r = a - b - 16'(c);
      f = fl & ~(FM_S | FM_Z | FM_X | FM_V | FM_C);
      if (half) begin
        f &= ~FM_H;
        if ({1'b0, a[11:0]} < {1'b0, b[11:0]} + 13'(c)) f |= FM_H;
      end
      f |= FM_N | sz16(r);
      if ({1'b0, a} < {1'b0, b} + 17'(c)) f |= FM_C | FM_X;
      if ((a[15] ^ b[15]) & (a[15] ^ r[15])) f |= FM_V;
      fl = f;
      sub16 = r;
    endfunction

    function logic [15:0] logic16(logic [15:0] r, logic is_and);
      fl = (fl & ~(FM_S | FM_Z | FM_H | FM_X | FM_N | FM_C)) | sz16(r)
           | (is_and ? FM_H : 8'h00);
      logic16 = r;
    endfunction

    function logic [7:0] inc8(logic [7:0] d);
      logic [7:0] n;
      logic [7:0] f;
      n = d + 8'd1;
      f = (fl & ~(FM_S | FM_Z | FM_H | FM_X | FM_V)) | sz8(n);
      if (d == 8'hff) f |= FM_X;
      if (d == 8'h7f) f |= FM_V;
      if (n[3:0] == 4'h0) f |= FM_H;
      fl = f;
      inc8 = n;
    endfunction

    function logic [7:0] dec8(logic [7:0] d);
      logic [7:0] n;
      logic [7:0] f;
      n = d - 8'd1;
      f = (fl & ~(FM_S | FM_Z | FM_H | FM_X | FM_V)) | FM_N | sz8(n);
      if (d == 8'h00) f |= FM_X;
      if (d == 8'h80) f |= FM_V;
      if (d[3:0] == 4'h0) f |= FM_H;
      fl = f;
      dec8 = n;
    endfunction

    // note an accepted request and queue its expected result
    function void note_request(logic [4:0] k, logic [15:0] w);
      logic [7:0] b;
      logic c;
      logic [15:0] v;
      logic wb;
      logic [7:0] f;
      b = w[7:0];
      c = fl[FB_C];
      v = '0;
      wb = 1'b1;
      case (k)
        K_INC8: v = 16'(inc8(b));
        K_INCX8: begin
          if (fl[FB_X]) v = 16'(inc8(b));
          else begin v = 16'(b); wb = 1'b0; end
        end
        K_DEC8: v = 16'(dec8(b));
        K_DECX8: begin
          if (fl[FB_X]) v = 16'(dec8(b));
          else begin v = 16'(b); wb = 1'b0; end
        end
        K_INC16, K_DEC16: begin
          f = fl & ~(FM_S | FM_Z | FM_X | FM_V | FM_N);
          v = (k == K_INC16) ? w + 16'd1 : w - 16'd1;
          if ((k == K_INC16 && v == 16'h0000) || (k == K_DEC16 && w == 16'h0000))
            f |= FM_X | FM_V;
          fl = f | sz16(v);
        end
        K_ADDA: begin acc = add8(acc, b, 1'b0); v = 16'(acc); end
        K_ADCA: begin acc = add8(acc, b, c); v = 16'(acc); end
        K_SUBA: begin acc = sub8(acc, b, 1'b0); v = 16'(acc); end
        K_SBCA: begin acc = sub8(acc, b, c); v = 16'(acc); end
        K_ANDA: begin acc = logic8(acc & b, 1'b1); v = 16'(acc); end
        K_XORA: begin acc = logic8(acc ^ b, 1'b0); v = 16'(acc); end
        K_ORA: begin acc = logic8(acc | b, 1'b0); v = 16'(acc); end
        K_CPA: begin v = 16'(sub8(acc, b, 1'b0)); wb = 1'b0; end
        K_ADDHL: begin hl = add16(hl, w, 1'b0); v = hl; end
        K_ADCHL: begin hl = add16(hl, w, c); v = hl; end
        K_SUBHL: begin hl = sub16(hl, w, 1'b0, 1'b0); v = hl; end
        K_SBCHL: begin hl = sub16(hl, w, c, 1'b1); v = hl; end
        K_ANDHL: begin hl = logic16(hl & w, 1'b1); v = hl; end
        K_XORHL: begin hl = logic16(hl ^ w, 1'b0); v = hl; end
        K_ORHL: begin hl = logic16(hl | w, 1'b0); v = hl; end
        K_LDA: begin acc = b; v = 16'(b); end
        K_LDHL: begin hl = w; v = w; end
        K_LDF: begin fl = b; v = 16'(b); end
        default: begin v = '0; wb = 1'b0; end
      endcase
      pending.push_back('{value: v, flags: fl, wb: wb});
    endfunction

    function void check_result(logic [15:0] v, logic [7:0] f, logic wb);
      alu_result_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result value=%h flags=%h wb=%b", v, f, wb);
        return;
      end
      e = pending.pop_front();
      if (e.value !== v || e.flags !== f || e.wb !== wb) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: exp value=%h flags=%h wb=%b, got value=%h flags=%h wb=%b",
                   checked, e.value, e.flags, e.wb, v, f, wb);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  in_kind = '0;
  logic [15:0] in_operand = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_value;
  logic [7:0]  out_flags_out;
  logic        out_write_back;

  alu_scoreboard sb;
  logic quiet_phase = 1'b0;
  logic hold_off = 1'b0;
  int   n_sent = 0;
  int   idle_cycles = 0;

  cpu_alu_8_16_with_flags dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_operand,
    .out_valid, .out_ready, .out_value, .out_flags_out, .out_write_back
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // send one request and hold it until accepted, with random gaps before it
  task automatic send_req(input logic [4:0] k, input logic [15:0] w);
    while (!quiet_phase && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_operand <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(k, w);
    n_sent++;
  endtask

  // one random request, mostly well-formed kinds
  task automatic send_random();
    logic [4:0] k;
    logic [15:0] w;
    k = ($urandom_range(99) < 3) ? 5'($urandom_range(31, 24)) : 5'($urandom_range(23));
    case ($urandom_range(7))
      0: w = 16'h0000;
      1: w = 16'hffff;
      2: w = {8'($urandom), 8'h7f};
      3: w = {8'($urandom), 8'h80};
      4: w = 16'h8000 ^ 16'($urandom_range(1));
      default: w = 16'($urandom);
    endcase
    send_req(k, w);
  endtask

  // receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 10);
  end

  // check accepted results
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_value, out_flags_out, out_write_back);
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // long receiver hold-off while requests keep coming
  initial begin
    wait (n_sent >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (60) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    sb = new();
    sb.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: flag chains, extremes and special cases
    send_req(K_INCX8, 16'h0012);
    send_req(K_INC8, 16'h00ff);
    send_req(K_INCX8, 16'h007f);
    send_req(K_DEC8, 16'h0000);
    send_req(K_DECX8, 16'h0080);
    send_req(K_INC16, 16'hffff);
    send_req(K_DEC16, 16'h0000);
    send_req(K_LDA, 16'hff7f);
    send_req(K_ADDA, 16'h0001);
    send_req(K_ADCA, 16'h00ff);
    send_req(K_SUBA, 16'h0080);
    send_req(K_SBCA, 16'h00ff);
    send_req(K_ANDA, 16'h000f);
    send_req(K_XORA, 16'h00ff);
    send_req(K_ORA, 16'h0000);
    send_req(K_CPA, 16'h00ff);
    send_req(K_LDHL, 16'h7fff);
    send_req(K_ADDHL, 16'h0001);
    send_req(K_ADCHL, 16'h8000);
    send_req(K_SUBHL, 16'hffff);
    send_req(K_SBCHL, 16'h0fff);
    send_req(K_ANDHL, 16'hffff);
    send_req(K_XORHL, 16'haaaa);
    send_req(K_ORHL, 16'h5555);
    send_req(K_LDF, 16'h00ff);
    send_req(5'd31, 16'h1234);
    // random: the normal mix, with a stretch of no idling in the middle
    for (int i = 0; i < 1625; i++) begin
      quiet_phase <= (i >= 600 && i < 800);
      if (i % 200 == 0) send_req(K_LDF, 16'($urandom));
      else send_random();
    end
    quiet_phase <= 1'b0;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("ran %0d requests over all 24 kinds plus unused codes, %0d results checked",
             n_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
